### src/button_click_classifier_defines.svh
// ----------------------------------------------------------------------------
// Button click classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define BCC_AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCC_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared types and constants of the click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned TIME_W = 32;

  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_DOUBLE = 2'd2;
  localparam logic [1:0] REG_LONG = 2'd3;

  localparam logic [7:0] RST_ENABLED = 8'd255;
  localparam logic [15:0] RST_DEBOUNCE = 16'd30;
  localparam logic [15:0] RST_DOUBLE = 16'd400;
  localparam logic [15:0] RST_LONG = 16'd800;

  localparam int unsigned EV_SINGLE_BIT = 0;
  localparam int unsigned EV_DOUBLE_BIT = 1;
  localparam int unsigned EV_LONG_BIT = 2;

  localparam logic [1:0] RES_LONG = 2'd0;
  localparam logic [1:0] RES_DOUBLE = 2'd1;
  localparam logic [1:0] RES_SINGLE = 2'd2;

  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] opb;
  } alu_req_t;

endpackage

### src/bcc_alu.sv
// ----------------------------------------------------------------------------
// Button click classifier shared adder
// One 32-bit add or subtract against the latched time stamp, shared by the
// edge and poll steps of the sequencer.
// ----------------------------------------------------------------------------
module bcc_alu (
  input  logic [bcc_pkg::TIME_W-1:0] opa,
  input  bcc_pkg::alu_req_t          req,
  output logic [bcc_pkg::TIME_W-1:0] res
);

  logic [bcc_pkg::TIME_W-1:0] opb_eff;

  assign opb_eff = req.sub ? ~req.opb : req.opb;
  assign res = opa + opb_eff + bcc_pkg::TIME_W'(req.sub);

endmodule

### src/button_click_classifier.sv
// ----------------------------------------------------------------------------
// Button click classifier
// Debounces button edges and classifies long presses, double clicks and
// single clicks; poll transactions report the queued events.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, in_kind, in_button, in_pressed, in_time_ms
// out     | output    | out_valid, out_ready, out_button_number, out_event_res, out_last
// cfg     | input     | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// After its handshake an edge transaction holds the input through four passes
// through the shared adder (EDEB, ECHK, EDL, EPT) and the update step EUPD; an
// edge that fails the debounce or level check frees it after ECHK, one for a
// disabled button at once. A poll takes PDL for a disabled button, PDL, PPT, PAPP,
// PEMIT and one PEMIT per reported event for an enabled one, then closes in PEND.
// Reset is synchronous and clears all per-button state at once.
// A stalled output holds the sequencer only when a further event must leave.
// ----------------------------------------------------------------------------
`include "button_click_classifier_defines.svh"

module button_click_classifier #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [2:0]  in_button,
  input  logic        in_pressed,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_button_number,
  output logic [1:0]  out_event_res,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int TW = bcc_pkg::TIME_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EDEB = 4'd1;
  localparam logic [3:0] S_ECHK = 4'd2;
  localparam logic [3:0] S_EDL = 4'd3;
  localparam logic [3:0] S_EPT = 4'd4;
  localparam logic [3:0] S_EUPD = 4'd5;
  localparam logic [3:0] S_PDL = 4'd6;
  localparam logic [3:0] S_PPT = 4'd7;
  localparam logic [3:0] S_PAPP = 4'd8;
  localparam logic [3:0] S_PEMIT = 4'd9;
  localparam logic [3:0] S_PEND = 4'd10;

  logic [7:0]  cfg_en_r;
  logic [15:0] cfg_deb_r;
  logic [15:0] cfg_dbl_r;
  logic [15:0] cfg_long_r;
  logic        cfg_wr;

  logic [3:0]  state_r, state_nxt;
  logic [IW-1:0] addr_r, addr_nxt;
  logic [TW-1:0] time_r, time_nxt;
  logic        lvl_r, lvl_nxt;
  logic [TW-1:0] diff_r;
  logic        rch_r, rch_nxt;
  logic        long_r, long_nxt;

  logic [NUM_BUTTONS-1:0] seen_r, seen_nxt;
  logic [NUM_BUTTONS-1:0] down_r, down_nxt;
  logic [NUM_BUTTONS-1:0] ldone_r, ldone_nxt;
  logic [NUM_BUTTONS-1:0] sw_r, sw_nxt;
  logic [NUM_BUTTONS-1:0] dm_r, dm_nxt;
  logic [2:0]  queued_r [NUM_BUTTONS];
  logic [2:0]  queued_nxt [NUM_BUTTONS];

  logic [TW-1:0] press_time_r [NUM_BUTTONS];
  logic [TW-1:0] last_edge_r [NUM_BUTTONS];
  logic [TW-1:0] deadline_r [NUM_BUTTONS];
  logic        pt_we, le_we, dl_we;

  logic [2:0]  pend_r, pend_nxt;
  logic        hold_v_r, hold_v_nxt;
  logic [3:0]  hold_num_r, hold_num_nxt;
  logic [1:0]  hold_ev_r, hold_ev_nxt;
  logic        out_v_r, out_v_nxt;
  logic [3:0]  out_num_r, out_num_nxt;
  logic [1:0]  out_ev_r, out_ev_nxt;
  logic        out_last_r, out_last_nxt;

  bcc_pkg::alu_req_t alu_req;
  logic [TW-1:0] alu_res;

  logic        out_free;
  logic        btn_ok;
  logic [15:0] en16;
  logic        deb_short;
  logic        ge_long;
  logic        poll_long;
  logic        poll_sw;
  logic        poll_single;
  logic [3:0]  cur_num;

  bcc_alu u_alu (
    .opa (time_r),
    .req (alu_req),
    .res (alu_res)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      bcc_pkg::REG_ENABLED:  prdata = {24'd0, cfg_en_r};
      bcc_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_deb_r};
      bcc_pkg::REG_DOUBLE:   prdata = {16'd0, cfg_dbl_r};
      bcc_pkg::REG_LONG:     prdata = {16'd0, cfg_long_r};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r   <= bcc_pkg::RST_ENABLED;
      cfg_deb_r  <= bcc_pkg::RST_DEBOUNCE;
      cfg_dbl_r  <= bcc_pkg::RST_DOUBLE;
      cfg_long_r <= bcc_pkg::RST_LONG;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bcc_pkg::REG_ENABLED:  cfg_en_r <= pwdata[7:0];
        bcc_pkg::REG_DEBOUNCE: cfg_deb_r <= pwdata[15:0];
        bcc_pkg::REG_DOUBLE:   cfg_dbl_r <= pwdata[15:0];
        bcc_pkg::REG_LONG:     cfg_long_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_v_r;
  assign out_button_number = out_num_r;
  assign out_event_res = out_ev_r;
  assign out_last = out_last_r;

  assign out_free = !out_v_r || out_ready;
  assign en16 = {8'd0, cfg_en_r};
  assign btn_ok = ({2'b00, in_button} < 5'(NUM_BUTTONS)) && cfg_en_r[in_button];
  assign deb_short = (diff_r[31:16] == 16'd0) && (diff_r[15:0] < cfg_deb_r);
  assign ge_long = (diff_r[31:16] != 16'd0) || (diff_r[15:0] >= cfg_long_r);
  assign poll_long = down_r[addr_r] && !ldone_r[addr_r] && ge_long;
  assign poll_sw = sw_r[addr_r] && !poll_long;
  assign poll_single = poll_sw && rch_r;
  assign cur_num = 4'(addr_r) + 4'd1;

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r;
    time_nxt = time_r;
    lvl_nxt = lvl_r;
    rch_nxt = rch_r;
    long_nxt = long_r;
    seen_nxt = seen_r;
    down_nxt = down_r;
    ldone_nxt = ldone_r;
    sw_nxt = sw_r;
    dm_nxt = dm_r;
    queued_nxt = queued_r;
    pend_nxt = pend_r;
    hold_v_nxt = hold_v_r;
    hold_num_nxt = hold_num_r;
    hold_ev_nxt = hold_ev_r;
    out_v_nxt = out_v_r && !out_ready;
    out_num_nxt = out_num_r;
    out_ev_nxt = out_ev_r;
    out_last_nxt = out_last_r;
    pt_we = 1'b0;
    le_we = 1'b0;
    dl_we = 1'b0;
    alu_req.sub = 1'b1;
    alu_req.opb = last_edge_r[addr_r];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          time_nxt = in_time_ms;
          lvl_nxt = in_pressed;
          if (in_kind) begin
            addr_nxt = '0;
            state_nxt = S_PDL;
          end else if (btn_ok) begin
            addr_nxt = IW'(in_button);
            state_nxt = S_EDEB;
          end
        end
      end
      S_EDEB: begin
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        alu_req.opb = deadline_r[addr_r];
        if ((seen_r[addr_r] && deb_short) || (!lvl_r && !down_r[addr_r])) begin
          state_nxt = S_IDLE;
        end else begin
          seen_nxt[addr_r] = 1'b1;
          le_we = 1'b1;
          state_nxt = S_EDL;
        end
      end
      S_EDL: begin
        rch_nxt = !diff_r[31];
        alu_req.opb = press_time_r[addr_r];
        state_nxt = S_EPT;
      end
      S_EPT: begin
        long_nxt = ge_long;
        alu_req.sub = 1'b0;
        alu_req.opb = {16'd0, cfg_dbl_r};
        state_nxt = S_EUPD;
      end
      S_EUPD: begin
        state_nxt = S_IDLE;
        if (lvl_r) begin
          if (sw_r[addr_r] && !rch_r) begin
            dm_nxt[addr_r] = 1'b1;
            sw_nxt[addr_r] = 1'b0;
          end else begin
            dm_nxt[addr_r] = 1'b0;
          end
          down_nxt[addr_r] = 1'b1;
          ldone_nxt[addr_r] = 1'b0;
          pt_we = 1'b1;
        end else begin
          down_nxt[addr_r] = 1'b0;
          if (ldone_r[addr_r]) begin
            dm_nxt[addr_r] = 1'b0;
            sw_nxt[addr_r] = 1'b0;
          end else if (long_r) begin
            queued_nxt[addr_r][bcc_pkg::EV_LONG_BIT] = 1'b1;
            ldone_nxt[addr_r] = 1'b1;
            sw_nxt[addr_r] = 1'b0;
            dm_nxt[addr_r] = 1'b0;
          end else if (dm_r[addr_r] && !rch_r) begin
            queued_nxt[addr_r][bcc_pkg::EV_DOUBLE_BIT] = 1'b1;
            dm_nxt[addr_r] = 1'b0;
          end else begin
            dm_nxt[addr_r] = 1'b0;
            sw_nxt[addr_r] = 1'b1;
            dl_we = 1'b1;
          end
        end
      end
      S_PDL: begin
        alu_req.opb = deadline_r[addr_r];
        if (en16[addr_r]) begin
          state_nxt = S_PPT;
        end else if (addr_r == IW'(NUM_BUTTONS - 1)) begin
          state_nxt = S_PEND;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_PPT: begin
        rch_nxt = !diff_r[31];
        alu_req.opb = press_time_r[addr_r];
        state_nxt = S_PAPP;
      end
      S_PAPP: begin
        if (poll_long) begin
          ldone_nxt[addr_r] = 1'b1;
          dm_nxt[addr_r] = 1'b0;
        end
        sw_nxt[addr_r] = poll_sw && !poll_single;
        pend_nxt = queued_r[addr_r] | {poll_long, 1'b0, poll_single};
        queued_nxt[addr_r] = 3'd0;
        state_nxt = S_PEMIT;
      end
      S_PEMIT: begin
        if (pend_r == 3'd0) begin
          if (addr_r == IW'(NUM_BUTTONS - 1)) begin
            state_nxt = S_PEND;
          end else begin
            addr_nxt = addr_r + 1'b1;
            state_nxt = S_PDL;
          end
        end else if (!hold_v_r || out_free) begin
          if (hold_v_r) begin
            out_v_nxt = 1'b1;
            out_num_nxt = hold_num_r;
            out_ev_nxt = hold_ev_r;
            out_last_nxt = 1'b0;
          end
          hold_v_nxt = 1'b1;
          hold_num_nxt = cur_num;
          if (pend_r[bcc_pkg::EV_LONG_BIT]) begin
            hold_ev_nxt = bcc_pkg::RES_LONG;
            pend_nxt[bcc_pkg::EV_LONG_BIT] = 1'b0;
          end else if (pend_r[bcc_pkg::EV_DOUBLE_BIT]) begin
            hold_ev_nxt = bcc_pkg::RES_DOUBLE;
            pend_nxt[bcc_pkg::EV_DOUBLE_BIT] = 1'b0;
          end else begin
            hold_ev_nxt = bcc_pkg::RES_SINGLE;
            pend_nxt[bcc_pkg::EV_SINGLE_BIT] = 1'b0;
          end
        end
      end
      S_PEND: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt = 1'b1;
          out_num_nxt = hold_num_r;
          out_ev_nxt = hold_ev_r;
          out_last_nxt = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      addr_r <= '0;
      seen_r <= '0;
      down_r <= '0;
      ldone_r <= '0;
      sw_r <= '0;
      dm_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        queued_r[i] <= 3'd0;
      end
      pend_r <= 3'd0;
      hold_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      seen_r <= seen_nxt;
      down_r <= down_nxt;
      ldone_r <= ldone_nxt;
      sw_r <= sw_nxt;
      dm_r <= dm_nxt;
      queued_r <= queued_nxt;
      pend_r <= pend_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    lvl_r <= lvl_nxt;
    rch_r <= rch_nxt;
    long_r <= long_nxt;
    diff_r <= alu_res;
    hold_num_r <= hold_num_nxt;
    hold_ev_r <= hold_ev_nxt;
    out_num_r <= out_num_nxt;
    out_ev_r <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_time_r[i] <= '0;
        last_edge_r[i] <= '0;
        deadline_r[i] <= '0;
      end
    end else begin
      if (pt_we) begin
        press_time_r[addr_r] <= time_r;
      end
      if (le_we) begin
        last_edge_r[addr_r] <= time_r;
      end
      if (dl_we) begin
        deadline_r[addr_r] <= diff_r;
      end
    end
  end

  `BCC_AST_IMPL(a_idle_hold_empty, state_r == S_IDLE, !hold_v_r, "hold register busy while idle")
  `BCC_AST_IMPL(a_pend_only_emit, state_r != S_PEMIT, pend_r == 3'd0, "pending events outside emit")
  `BCC_AST_NEXT(a_end_to_idle, (state_r == S_PEND) && !hold_v_r, state_r == S_IDLE, "poll stuck")
  `BCC_AST_IMPL(a_addr_range, state_r != S_IDLE, addr_r <= IW'(NUM_BUTTONS - 1), "bad button index")

endmodule
